### src/pogu_pkg.sv
// ----------------------------------------------------------------------------
// Occupancy grid update package
// Shared types, register codes and map state codes for the grid update block.
// ----------------------------------------------------------------------------
package pogu_pkg;

   // Pixel position counters and their recompute divider.
   localparam int POS_W  = 12;
   localparam int STEP_W = $clog2(POS_W + 1);

   // Largest grid supported by the fixed-width item fields.
   localparam int MAX_COL_W = 6;
   localparam int MAX_ROW_W = 6;
   localparam int MAX_IDX_W = 12;

   localparam int COUNT_W = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
   localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
   localparam logic [1:0] REG_ROW_LENGTH  = 2'd2;

   localparam logic [7:0]       CELL_WIDTH_RST  = 8'd64;
   localparam logic [7:0]       CELL_HEIGHT_RST = 8'd50;
   localparam logic [POS_W-1:0] ROW_LENGTH_RST  = 12'd1280;

   // Map cell states.
   localparam logic [1:0] ST_UNKNOWN  = 2'd0;
   localparam logic [1:0] ST_FREE     = 2'd1;
   localparam logic [1:0] ST_OBSTACLE = 2'd2;

   typedef struct packed {
      logic [7:0]       cell_width;
      logic [7:0]       cell_height;
      logic [POS_W-1:0] row_length;
   } pogu_cfg_type;

   typedef struct packed {
      logic pixel_on;
      logic frame_start;
   } pogu_req_type;

   typedef struct packed {
      logic [3:0]         cell_row;
      logic [4:0]         cell_col;
      logic [COUNT_W-1:0] white_count;
      logic               observed_obstacle;
      logic [1:0]         new_state;
      logic               state_changed;
   } pogu_rsp_type;

   // One classified pixel travelling from the front to the back.
   typedef struct packed {
      logic                 pixel_on;
      logic                 clear;
      logic                 in_grid;
      logic                 first;
      logic                 last;
      logic [MAX_COL_W-1:0] col;
      logic [MAX_ROW_W-1:0] row;
      logic [MAX_IDX_W-1:0] idx;
   } pogu_item_type;

endpackage

### src/pogu_fifo.sv
// ----------------------------------------------------------------------------
// Small register queue
// A shallow first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module pogu_fifo #(
   parameter type ITEM_TYPE = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  ITEM_TYPE wr_data,
   output logic     full,
   input  logic     pop,
   output ITEM_TYPE rd_data,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ITEM_TYPE         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### src/pogu_front.sv
// ----------------------------------------------------------------------------
// Grid update front end
// Tracks the raster position and classifies each pixel against the cell grid.
// ----------------------------------------------------------------------------
module pogu_front import pogu_pkg::*; #(
   parameter int GRID_ROWS = 10,
   parameter int GRID_COLS = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  pogu_cfg_type  cfg,
   input  logic          cfg_wr,
   input  logic          stall,
   input  logic          push,
   input  pogu_req_type  req_data,
   output logic          full,
   output logic          q_push,
   output pogu_item_type q_data
);

   // Position in pixels, offset inside the cell and cell coordinates.
   logic [POS_W-1:0]  x_ff, x_in;
   logic [POS_W-1:0]  y_ff, y_in;
   logic [7:0]        sx_ff, sx_in;
   logic [7:0]        sy_ff, sy_in;
   logic [POS_W-1:0]  col_ff, col_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic             accept;
   logic             fs;
   logic [POS_W-1:0] cx, cy, ccol, crow;
   logic [7:0]       csx, csy;
   logic [7:0]       cw1, ch1;
   logic [POS_W-1:0] rl1;
   logic [8:0]       rem_x, rem_y;
   logic             ge_x, ge_y;
   logic             in_grid;

   assign full   = busy_ff || stall;
   assign accept = push && !full;
   assign q_push = accept;

   assign fs   = req_data.frame_start;
   assign cx   = fs ? '0 : x_ff;
   assign cy   = fs ? '0 : y_ff;
   assign csx  = fs ? '0 : sx_ff;
   assign csy  = fs ? '0 : sy_ff;
   assign ccol = fs ? '0 : col_ff;
   assign crow = fs ? '0 : row_ff;

   assign cw1 = cfg.cell_width - 8'd1;
   assign ch1 = cfg.cell_height - 8'd1;
   assign rl1 = cfg.row_length - 12'd1;

   // One restoring division step per cycle, on both axes at once. The
   // dividend shifts out of the cell coordinate registers while the quotient
   // shifts in, and the remainder builds up in the offset registers.
   assign rem_x = {sx_ff, col_ff[POS_W-1]};
   assign rem_y = {sy_ff, row_ff[POS_W-1]};
   assign ge_x  = (rem_x >= {1'b0, cfg.cell_width});
   assign ge_y  = (rem_y >= {1'b0, cfg.cell_height});

   assign in_grid = (cfg.cell_width != 8'd0) && (cfg.cell_height != 8'd0) &&
                    (ccol < POS_W'(GRID_COLS)) && (crow < POS_W'(GRID_ROWS));

   always_comb begin
      q_data.pixel_on = req_data.pixel_on;
      q_data.clear    = fs;
      q_data.in_grid  = in_grid;
      q_data.first    = (csx == 8'd0) && (csy == 8'd0);
      q_data.last     = (csx == cw1) && (csy == ch1);
      q_data.col      = ccol[MAX_COL_W-1:0];
      q_data.row      = crow[MAX_ROW_W-1:0];
      q_data.idx      = MAX_IDX_W'(crow[MAX_ROW_W-1:0]) * MAX_IDX_W'(GRID_COLS) +
                        MAX_IDX_W'(ccol[MAX_COL_W-1:0]);
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (cfg_wr) begin
         // New cell geometry: recompute the cell coordinates of the position.
         // A write that lands during a recompute starts it over.
         col_in  = x_ff;
         row_in  = y_ff;
         sx_in   = '0;
         sy_in   = '0;
         step_in = STEP_W'(POS_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sx_in   = ge_x ? 8'(rem_x - {1'b0, cfg.cell_width}) : rem_x[7:0];
         sy_in   = ge_y ? 8'(rem_y - {1'b0, cfg.cell_height}) : rem_y[7:0];
         col_in  = {col_ff[POS_W-2:0], ge_x};
         row_in  = {row_ff[POS_W-2:0], ge_y};
         step_in = step_ff - 1'b1;
         busy_in = (step_ff != STEP_W'(1));
      end else if (accept) begin
         if (cx == rl1) begin
            x_in   = '0;
            sx_in  = '0;
            col_in = '0;
            y_in   = cy + 1'b1;
            if (cy == {POS_W{1'b1}}) begin
               sy_in  = '0;
               row_in = '0;
            end else if (csy == ch1) begin
               sy_in  = '0;
               row_in = crow + 1'b1;
            end else begin
               sy_in  = csy + 1'b1;
               row_in = crow;
            end
         end else begin
            y_in   = cy;
            sy_in  = csy;
            row_in = crow;
            if (cx == {POS_W{1'b1}}) begin
               x_in   = '0;
               sx_in  = '0;
               col_in = '0;
            end else begin
               x_in = cx + 1'b1;
               if (csx == cw1) begin
                  sx_in  = '0;
                  col_in = ccol + 1'b1;
               end else begin
                  sx_in  = csx + 1'b1;
                  col_in = ccol;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         sx_ff   <= '0;
         sy_ff   <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

### src/pogu_back.sv
// ----------------------------------------------------------------------------
// Grid update back end
// Accumulates cell counts per grid column and updates the persistent map.
// ----------------------------------------------------------------------------
module pogu_back import pogu_pkg::*; #(
   parameter int GRID_ROWS = 10,
   parameter int GRID_COLS = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  pogu_cfg_type  cfg,
   input  logic          q_empty,
   input  pogu_item_type q_data,
   output logic          q_pop,
   input  logic          out_full,
   output logic          out_push,
   output pogu_rsp_type  out_data,
   output logic          clearing
);

   localparam int CELLS = GRID_ROWS * GRID_COLS;
   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

   logic [COUNT_W-1:0] cnt_mem [GRID_COLS];
   logic [1:0]         occ_mem [CELLS];

   logic [COUNT_W-2:0] half_ff;
   logic               stage_vld_ff, stage_vld_in;
   pogu_item_type      stage_ff;
   logic [COUNT_W-1:0] cnt_q_ff;
   logic [1:0]         occ_q_ff;
   logic [GRID_COLS-1:0] cvalid_ff, cvalid_in;
   logic               cfwd_vld_ff, cfwd_vld_in;
   logic [COL_W-1:0]   cfwd_col_ff;
   logic [COUNT_W-1:0] cfwd_val_ff;
   logic               ofwd_vld_ff;
   logic [IDX_W-1:0]   ofwd_idx_ff;
   logic [1:0]         ofwd_val_ff;
   logic               clearing_ff;
   logic [IDX_W-1:0]   clr_idx_ff;

   logic [COL_W-1:0]   scol;
   logic [IDX_W-1:0]   sidx;
   logic [COUNT_W-1:0] c_old, c_new, c_store;
   logic               obs_obst;
   logic [1:0]         o_old, o_new;
   logic               has_res, done, load;

   assign clearing = clearing_ff;
   assign scol     = stage_ff.col[COL_W-1:0];
   assign sidx     = stage_ff.idx[IDX_W-1:0];

   // The read data was taken when the item entered the stage; a write made
   // by the item just ahead of it is picked up from the bypass registers.
   always_comb begin
      if (cfwd_vld_ff && (cfwd_col_ff == scol)) begin
         c_old = cfwd_val_ff;
      end else if (cvalid_ff[scol]) begin
         c_old = cnt_q_ff;
      end else begin
         c_old = '0;
      end
      c_new   = stage_ff.first ? COUNT_W'(stage_ff.pixel_on)
                               : c_old + COUNT_W'(stage_ff.pixel_on);
      c_store = stage_ff.last ? '0 : c_new;

      obs_obst = !(c_new > {1'b0, half_ff});
      o_old    = (ofwd_vld_ff && (ofwd_idx_ff == sidx)) ? ofwd_val_ff : occ_q_ff;
      if (o_old == ST_UNKNOWN) begin
         o_new = obs_obst ? ST_OBSTACLE : ST_FREE;
      end else if ((o_old == ST_FREE) && obs_obst) begin
         o_new = ST_OBSTACLE;
      end else begin
         o_new = o_old;
      end
   end

   assign has_res  = stage_vld_ff && stage_ff.in_grid && stage_ff.last;
   assign done     = stage_vld_ff && !(has_res && out_full);
   assign load     = !q_empty && !clearing_ff && (!stage_vld_ff || done);
   assign q_pop    = load;
   assign out_push = done && has_res;

   always_comb begin
      out_data.cell_row          = 4'(stage_ff.row);
      out_data.cell_col          = 5'(stage_ff.col);
      out_data.white_count       = c_new;
      out_data.observed_obstacle = obs_obst;
      out_data.new_state         = o_new;
      out_data.state_changed     = (o_new != o_old);
   end

   always_comb begin
      stage_vld_in = stage_vld_ff;
      if (load) begin
         stage_vld_in = 1'b1;
      end else if (done) begin
         stage_vld_in = 1'b0;
      end

      // A frame start wipes every column count before its own pixel counts.
      cvalid_in   = cvalid_ff;
      cfwd_vld_in = cfwd_vld_ff;
      if (done) begin
         if (stage_ff.clear) begin
            cvalid_in   = '0;
            cfwd_vld_in = 1'b0;
         end
         if (stage_ff.in_grid) begin
            cvalid_in[scol] = 1'b1;
            cfwd_vld_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         cvalid_ff    <= '0;
         cfwd_vld_ff  <= 1'b0;
         ofwd_vld_ff  <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
      end else begin
         stage_vld_ff <= stage_vld_in;
         cvalid_ff    <= cvalid_in;
         cfwd_vld_ff  <= cfwd_vld_in;
         if (out_push) begin
            ofwd_vld_ff <= 1'b1;
         end
         if (clearing_ff) begin
            if (clr_idx_ff == IDX_W'(CELLS - 1)) begin
               clearing_ff <= 1'b0;
            end else begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      half_ff <= (COUNT_W-1)'((COUNT_W'(cfg.cell_width) * COUNT_W'(cfg.cell_height)) >> 1);
      if (load) begin
         stage_ff <= q_data;
      end
      if (done && stage_ff.in_grid) begin
         cfwd_col_ff <= scol;
         cfwd_val_ff <= c_store;
      end
      if (out_push) begin
         ofwd_idx_ff <= sidx;
         ofwd_val_ff <= o_new;
      end
   end

   always_ff @(posedge clock) begin
      if (done && stage_ff.in_grid) begin
         cnt_mem[scol] <= c_store;
      end
      if (load) begin
         cnt_q_ff <= cnt_mem[q_data.col[COL_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         occ_mem[clr_idx_ff] <= ST_UNKNOWN;
      end else if (out_push) begin
         occ_mem[sidx] <= o_new;
      end
      if (load) begin
         occ_q_ff <= occ_mem[q_data.idx[IDX_W-1:0]];
      end
   end

endmodule

### src/persistent_occupancy_grid_update.sv
// ----------------------------------------------------------------------------
// Persistent occupancy grid update
// Tiles a binary pixel stream into grid cells and keeps a sticky obstacle map.
// ----------------------------------------------------------------------------
// Pixels enter in raster order through push/full, one per cycle when full is
// low; frame_start places a pixel at the top-left corner of the region. Each
// pixel that completes a grid cell yields one result on rsp_data, held while
// empty is low and taken with pop. While neither side stalls, the sustained
// rate is one pixel per cycle: the front end tracks the position with
// counters and the back end does one count and one map read-modify-write
// per cycle, bypassing the item just ahead.
// Short queues on both sides of the back end let either side stall alone;
// when pop is held low, results collect in the output queue and full rises
// once it and the internal queue fill up.
// After reset, full stays high while every cell of the map is swept to
// unknown. Each configuration write raises full while the cell coordinates
// of the current pixel position are recomputed by a one-bit-per-cycle
// divider.
// ----------------------------------------------------------------------------
module persistent_occupancy_grid_update import pogu_pkg::*; #(
   parameter int GRID_ROWS = 10,
   parameter int GRID_COLS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pogu_req_type          req_data,
   output logic                  full,
   output logic                  empty,
   input  logic                  pop,
   output pogu_rsp_type          rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   pogu_cfg_type  cfg_ff;
   logic          cfg_wr;
   logic [1:0]    reg_sel;

   logic          q_full, q_empty, q_push, q_pop;
   pogu_item_type q_wr_data, q_rd_data;
   logic          out_full, out_push;
   pogu_rsp_type  out_data;
   logic          back_clearing;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign reg_sel = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_width  <= CELL_WIDTH_RST;
         cfg_ff.cell_height <= CELL_HEIGHT_RST;
         cfg_ff.row_length  <= ROW_LENGTH_RST;
      end else if (cfg_wr) begin
         unique case (reg_sel)
            REG_CELL_WIDTH:  cfg_ff.cell_width  <= pwdata[7:0];
            REG_CELL_HEIGHT: cfg_ff.cell_height <= pwdata[7:0];
            REG_ROW_LENGTH:  cfg_ff.row_length  <= pwdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CELL_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.cell_width);
         REG_CELL_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.cell_height);
         REG_ROW_LENGTH:  prdata = CSR_DATA_W'(cfg_ff.row_length);
         default:         prdata = '0;
      endcase
   end

   pogu_front #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .cfg_wr   (cfg_wr),
      .stall    (q_full || back_clearing),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   pogu_fifo #(
      .ITEM_TYPE (pogu_item_type),
      .DEPTH     (2)
   ) u_item_q (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   pogu_back #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_data   (q_rd_data),
      .q_pop    (q_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_data (out_data),
      .clearing (back_clearing)
   );

   pogu_fifo #(
      .ITEM_TYPE (pogu_rsp_type),
      .DEPTH     (2)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .pop     (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

`ifndef SYNTHESIS
   // The back end only completes a cell when the output queue has room.
   assert property (@(posedge clock) disable iff (reset) out_push |-> !out_full)
      else $error("result transfer into a full output queue");

   // The back end never takes an item the internal queue does not hold.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("item taken from an empty internal queue");

   // No pixel enters while the map is still being swept after reset.
   assert property (@(posedge clock) disable iff (reset)
                    back_clearing |-> !(push && !full))
      else $error("pixel accepted during the map sweep");

   // A changed cell always takes the state of this frame's observation.
   assert property (@(posedge clock) disable iff (reset)
                    (!empty && rsp_data.state_changed) |->
                    ((rsp_data.observed_obstacle && rsp_data.new_state == ST_OBSTACLE) ||
                     (!rsp_data.observed_obstacle && rsp_data.new_state == ST_FREE)))
      else $error("map state change disagrees with the observation");
`endif

endmodule
